FILE: rtl/core/qbb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qbb_pkg
// Shared constants for the quadratic Bezier bounding box block.
// ----------------------------------------------------------------------------
package qbb_pkg;

  localparam int DEF_COORD_WIDTH = 24;
  localparam int DEF_T_BITS      = 16;
  // Lane stages besides the divider steps: front, product, inner term,
  // partial products, rounding and the final min/max.
  localparam int LANE_EXTRA_STAGES = 6;

endpackage : qbb_pkg
`default_nettype wire

FILE: rtl/core/qbb_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qbb_in_if / qbb_out_if
// Valid/ready channels for curve items and bounding box items.
// ----------------------------------------------------------------------------
interface qbb_in_if #(parameter int W = 24);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] start_x;
  logic signed [W-1:0] start_y;
  logic signed [W-1:0] control_x;
  logic signed [W-1:0] control_y;
  logic signed [W-1:0] end_x;
  logic signed [W-1:0] end_y;

  modport source (output valid, start_x, start_y, control_x, control_y, end_x, end_y,
                  input ready);
  modport sink   (input valid, start_x, start_y, control_x, control_y, end_x, end_y,
                  output ready);
endinterface : qbb_in_if

interface qbb_out_if #(parameter int W = 24);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] min_x;
  logic signed [W-1:0] min_y;
  logic signed [W-1:0] max_x;
  logic signed [W-1:0] max_y;

  modport source (output valid, min_x, min_y, max_x, max_y, input ready);
  modport sink   (input valid, min_x, min_y, max_x, max_y, output ready);
endinterface : qbb_out_if
`default_nettype wire

FILE: rtl/core/quadratic_bezier_bbox.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// quadratic_bezier_bbox
// Bounding box of a quadratic Bezier curve, one box per item.
// ----------------------------------------------------------------------------
// Each item on in_if carries the start, control and end points of a curve.
// Each item on out_if carries the box as min_x, min_y, max_x and max_y.
// The x and y axes run in two identical lanes side by side, and the last
// stage joins their ranges into one box item.
// The extremum parameter comes from a divider that finds one quotient bit
// per stage, followed by the product, rounding and range stages.
// Throughput is one item per cycle when the receiver keeps out_if.ready high.
// Every stage holds its own valid bit, so a bubble in the pipeline is closed
// up even while the receiver stalls; in_if.ready falls only once all stages
// hold items. A stalled box item holds its value until taken.
// Synchronous reset clears the valid bits; no item is in flight after it.
// ----------------------------------------------------------------------------
module quadratic_bezier_bbox import qbb_pkg::*; #(
  parameter int COORD_WIDTH = DEF_COORD_WIDTH,
  parameter int T_BITS      = DEF_T_BITS
) (
  input wire logic  clk,
  input wire logic  rst_n,
  qbb_in_if.sink    in_if,
  qbb_out_if.source out_if
);

  localparam int NS = T_BITS + LANE_EXTRA_STAGES;

  logic [NS-1:0] vld_r, vld_nxt;
  logic [NS-1:0] en;

  always_comb begin
    en[NS-1] = !vld_r[NS-1] || out_if.ready;
    for (int i = NS - 2; i >= 0; i--) begin
      en[i] = !vld_r[i] || en[i+1];
    end
    for (int i = 0; i < NS; i++) begin
      if (en[i]) begin
        vld_nxt[i] = (i == 0) ? in_if.valid : vld_r[(i == 0) ? 0 : i - 1];
      end else begin
        vld_nxt[i] = vld_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  qbb_lane #(.W(COORD_WIDTH), .T(T_BITS), .NS(NS)) u_lane_x (
    .clk  (clk),
    .en   (en),
    .p1_i (in_if.start_x),
    .p2_i (in_if.control_x),
    .p3_i (in_if.end_x),
    .lo_o (out_if.min_x),
    .hi_o (out_if.max_x)
  );

  qbb_lane #(.W(COORD_WIDTH), .T(T_BITS), .NS(NS)) u_lane_y (
    .clk  (clk),
    .en   (en),
    .p1_i (in_if.start_y),
    .p2_i (in_if.control_y),
    .p3_i (in_if.end_y),
    .lo_o (out_if.min_y),
    .hi_o (out_if.max_y)
  );

  assign in_if.ready  = en[0];
  assign out_if.valid = vld_r[NS-1];

`ifndef ASSERT_OFF
  a_box_x_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid |-> (out_if.min_x <= out_if.max_x))
    else $error("box item with min_x above max_x");

  a_box_y_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid |-> (out_if.min_y <= out_if.max_y))
    else $error("box item with min_y above max_y");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_if.valid)
    else $error("box item valid right after reset");

  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (!in_if.ready) |-> (&vld_r && !out_if.ready))
    else $error("input stalled while the pipeline has room");
`endif

endmodule : quadratic_bezier_bbox
`default_nettype wire

FILE: rtl/core/qbb_div_step.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qbb_div_step
// One registered restoring division step: one quotient bit per stage.
// ----------------------------------------------------------------------------
module qbb_div_step import qbb_pkg::*; #(
  parameter int AW = 26,
  parameter int T  = 16
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [AW-1:0] ad_i,
  input  wire logic [AW-1:0] rem_i,
  input  wire logic [T-1:0]  q_i,
  output logic      [AW-1:0] rem_o,
  output logic      [T-1:0]  q_o
);

  logic [AW:0]   shifted;
  logic [AW:0]   diff;
  logic          take;
  logic [AW-1:0] rem_r, rem_nxt;
  logic [T-1:0]  q_r, q_nxt;

  always_comb begin
    shifted = {rem_i, 1'b0};
    diff    = shifted - {1'b0, ad_i};
    take    = (shifted >= {1'b0, ad_i});
    rem_nxt = take ? diff[AW-1:0] : shifted[AW-1:0];
    q_nxt   = {q_i[T-2:0], take};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
    end
  end

  assign rem_o = rem_r;
  assign q_o   = q_r;

endmodule : qbb_div_step
`default_nettype wire

FILE: rtl/core/qbb_lane.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qbb_lane
// Pipelined range finder for one axis: end range, extremum parameter,
// curve value at the extremum and the widened range.
// ----------------------------------------------------------------------------
module qbb_lane import qbb_pkg::*; #(
  parameter int W  = DEF_COORD_WIDTH,
  parameter int T  = DEF_T_BITS,
  parameter int NS = T + LANE_EXTRA_STAGES
) (
  input  wire logic                clk,
  input  wire logic [NS-1:0]       en,
  input  wire logic signed [W-1:0] p1_i,
  input  wire logic signed [W-1:0] p2_i,
  input  wire logic signed [W-1:0] p3_i,
  output logic signed [W-1:0]      lo_o,
  output logic signed [W-1:0]      hi_o
);

  localparam int AW = W + 2;
  localparam int MW = W + T + 4;
  localparam int SL = MW / 2;
  localparam int SH = MW - SL;
  localparam int SW = MW + T + 1;
  localparam int DW = W + 3;

  // Fields carried down the pipeline, one register per stage.
  logic signed [W-1:0]  p1_r  [NS];
  logic signed [W-1:0]  mn_r  [NS];
  logic signed [W-1:0]  mx_r  [NS];
  logic signed [W:0]    num_r [NS];
  logic signed [W+1:0]  den_r [NS];
  logic [AW-1:0]        ad_r  [NS];
  logic                 ok_r  [NS];

  logic [AW-1:0] rem_w [T+1];
  logic [T-1:0]  q_w   [T+1];

  // Front stage.
  logic signed [W:0]   num_nxt;
  logic signed [W+1:0] den_nxt;
  logic [AW-1:0]       an_nxt, ad_nxt;
  logic                ok_nxt;
  logic [AW-1:0]       an_r;

  always_comb begin
    num_nxt = {p1_i[W-1], p1_i} - {p2_i[W-1], p2_i};
    den_nxt = {{2{p1_i[W-1]}}, p1_i} - {p2_i[W-1], p2_i, 1'b0} + {{2{p3_i[W-1]}}, p3_i};
    an_nxt  = num_nxt[W] ? AW'(-{num_nxt[W], num_nxt}) : AW'(num_nxt);
    ad_nxt  = den_nxt[W+1] ? AW'(-den_nxt) : AW'(den_nxt);
    ok_nxt  = (den_nxt != '0) && (num_nxt != '0) && (num_nxt[W] == den_nxt[W+1])
              && (an_nxt < ad_nxt);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      p1_r[0]  <= p1_i;
      mn_r[0]  <= (p1_i < p3_i) ? p1_i : p3_i;
      mx_r[0]  <= (p1_i < p3_i) ? p3_i : p1_i;
      num_r[0] <= num_nxt;
      den_r[0] <= den_nxt;
      ad_r[0]  <= ad_nxt;
      ok_r[0]  <= ok_nxt;
      an_r     <= an_nxt;
    end
  end

  assign rem_w[0] = an_r;
  assign q_w[0]   = '0;

  // Divider steps and the carried fields beside them.
  for (genvar i = 1; i <= T; i++) begin : g_div
    qbb_div_step #(.AW(AW), .T(T)) u_step (
      .clk   (clk),
      .en    (en[i]),
      .ad_i  (ad_r[i-1]),
      .rem_i (rem_w[i-1]),
      .q_i   (q_w[i-1]),
      .rem_o (rem_w[i]),
      .q_o   (q_w[i])
    );
  end

  for (genvar i = 1; i < NS; i++) begin : g_carry
    always_ff @(posedge clk) begin
      if (en[i]) begin
        p1_r[i]  <= p1_r[i-1];
        num_r[i] <= num_r[i-1];
        den_r[i] <= den_r[i-1];
        ad_r[i]  <= ad_r[i-1];
        mn_r[i]  <= mn_r[i-1];
        mx_r[i]  <= mx_r[i-1];
        if (i == T + 1) begin
          ok_r[i] <= ok_r[i-1] && (q_w[T] != '0);
        end else begin
          ok_r[i] <= ok_r[i-1];
        end
      end
    end
  end

  // Product tq * den.
  logic [T-1:0]          tq_r [T+1:T+3];
  logic signed [MW-1:0]  prod_r;
  logic signed [MW-1:0]  inner_nxt;
  logic [MW-1:0]         imag_r;
  logic                  ineg_r [T+2:T+4];
  logic [SL+T-1:0]       pl_r;
  logic [SH+T-1:0]       ph_r;
  logic [SW-1:0]         sum_nxt;
  logic [DW-1:0]         d_r;

  always_ff @(posedge clk) begin
    if (en[T+1]) begin
      tq_r[T+1] <= q_w[T];
      prod_r    <= MW'($signed({1'b0, q_w[T]}) * den_r[T]);
    end
  end

  assign inner_nxt = prod_r - (MW'(num_r[T+1]) <<< (T + 1));

  always_ff @(posedge clk) begin
    if (en[T+2]) begin
      tq_r[T+2]   <= tq_r[T+1];
      imag_r      <= inner_nxt[MW-1] ? MW'(-inner_nxt) : MW'(inner_nxt);
      ineg_r[T+2] <= inner_nxt[MW-1];
    end
    if (en[T+3]) begin
      tq_r[T+3]   <= tq_r[T+2];
      pl_r        <= imag_r[SL-1:0] * tq_r[T+2];
      ph_r        <= imag_r[MW-1:SL] * tq_r[T+2];
      ineg_r[T+3] <= ineg_r[T+2];
    end
  end

  assign sum_nxt = SW'(pl_r) + (SW'(ph_r) << SL) + (SW'(1) << (2 * T - 1));

  always_ff @(posedge clk) begin
    if (en[T+4]) begin
      d_r         <= DW'(sum_nxt >> (2 * T));
      ineg_r[T+4] <= ineg_r[T+3];
    end
  end

  // Final stage: curve value at the extremum widens the range.
  logic signed [DW-1:0] p1x, v;
  logic signed [DW-1:0] mnx, mxx;
  logic signed [W-1:0]  lo_r, hi_r;

  always_comb begin
    p1x = DW'(p1_r[T+4]);
    mnx = DW'(mn_r[T+4]);
    mxx = DW'(mx_r[T+4]);
    v   = ineg_r[T+4] ? (p1x - $signed(d_r)) : (p1x + $signed(d_r));
  end

  always_ff @(posedge clk) begin
    if (en[NS-1]) begin
      lo_r <= (ok_r[T+4] && (v < mnx)) ? W'(v) : mn_r[T+4];
      hi_r <= (ok_r[T+4] && (v > mxx)) ? W'(v) : mx_r[T+4];
    end
  end

  assign lo_o = lo_r;
  assign hi_o = hi_r;

endmodule : qbb_lane
`default_nettype wire

FILE: test/quadratic_bezier_bbox_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadratic_bezier_bbox_tb
// Streams curve items through the bounding box block with random gaps on both
// sides and compares every box item against an exact integer predictor.
// ----------------------------------------------------------------------------

class bbox_scoreboard;
  typedef struct packed {
    logic signed [23:0] min_x;
    logic signed [23:0] min_y;
    logic signed [23:0] max_x;
    logic signed [23:0] max_y;
  } box_t;

  box_t pending_boxes[$];
  int   mismatches;

  // Extends the axis range with the interior extremum, when there is one.
  function automatic void widen_axis(input longint p1, input longint p2, input longint p3,
                                     output longint lo, output longint hi);
    longint num, den, an, ad, tq, inner, v;
    logic [127:0] prod;
    lo = (p1 < p3) ? p1 : p3;
    hi = (p1 < p3) ? p3 : p1;
    num = p1 - p2;
    den = p1 - 2 * p2 + p3;
    an = (num < 0) ? -num : num;
    ad = (den < 0) ? -den : den;
    if (den != 0 && num != 0 && ((num < 0) == (den < 0)) && an < ad) begin
      tq = (an <<< 16) / ad;
      if (tq > 0) begin
        inner = tq * den - num * (longint'(1) <<< 17);
        prod = 128'((inner < 0) ? -inner : inner) * 128'(tq) + (128'(1) << 31);
        v = (inner < 0) ? p1 - longint'(prod >> 32) : p1 + longint'(prod >> 32);
        if (v < lo) lo = v;
        if (v > hi) hi = v;
      end
    end
  endfunction

  function void note_curve(input logic signed [23:0] sx, input logic signed [23:0] sy,
                           input logic signed [23:0] cx, input logic signed [23:0] cy,
                           input logic signed [23:0] ex, input logic signed [23:0] ey);
    longint x_lo, x_hi, y_lo, y_hi;
    box_t b;
    widen_axis(sx, cx, ex, x_lo, x_hi);
    widen_axis(sy, cy, ey, y_lo, y_hi);
    b.min_x = x_lo[23:0];
    b.min_y = y_lo[23:0];
    b.max_x = x_hi[23:0];
    b.max_y = y_hi[23:0];
    pending_boxes.push_back(b);
  endfunction

  function void check_box(input box_t got);
    box_t want;
    if (pending_boxes.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected box item %h", got);
      return;
    end
    want = pending_boxes.pop_front();
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("box mismatch: expected %0d %0d %0d %0d, got %0d %0d %0d %0d",
                 want.min_x, want.min_y, want.max_x, want.max_y,
                 got.min_x, got.min_y, got.max_x, got.max_y);
    end
  endfunction
endclass

module quadratic_bezier_bbox_tb;
  import qbb_pkg::*;

  localparam int LATENCY = DEF_T_BITS + LANE_EXTRA_STAGES;
  localparam int STALL_LIMIT = 2000;
  localparam logic signed [23:0] CMAX = 24'sh7FFFFF;
  localparam logic signed [23:0] CMIN = -24'sh800000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  bit   timed_out = 1'b0;
  bit   sending_done = 1'b0;
  int   idle_cycles = 0;

  qbb_in_if  #(.W(24)) in_if ();
  qbb_out_if #(.W(24)) out_if ();

  quadratic_bezier_bbox u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_if),
    .out_if(out_if)
  );

  bbox_scoreboard scoreboard = new();

  always #5 clk = ~clk;

  initial begin
    in_if.valid = 1'b0;
    in_if.start_x = '0;
    in_if.start_y = '0;
    in_if.control_x = '0;
    in_if.control_y = '0;
    in_if.end_x = '0;
    in_if.end_y = '0;
    out_if.ready = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_if.valid && in_if.ready)
        scoreboard.note_curve(in_if.start_x, in_if.start_y, in_if.control_x,
                              in_if.control_y, in_if.end_x, in_if.end_y);
      if (out_if.valid && out_if.ready)
        scoreboard.check_box({out_if.min_x, out_if.min_y, out_if.max_x, out_if.max_y});
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (sending_done && scoreboard.pending_boxes.size() == 0))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) timed_out <= 1'b1;
    end
  end

  // Receiver: random stall before each box item.
  initial begin
    int gap;
    @(posedge rst_n);
    forever begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
      repeat (gap) begin
        @(negedge clk);
        out_if.ready <= 1'b0;
      end
      @(negedge clk);
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!(out_if.valid && out_if.ready));
    end
  end

  task automatic send_curve(input logic signed [23:0] sx, input logic signed [23:0] sy,
                            input logic signed [23:0] cx, input logic signed [23:0] cy,
                            input logic signed [23:0] ex, input logic signed [23:0] ey,
                            input int gap);
    repeat (gap) begin
      @(negedge clk);
      in_if.valid <= 1'b0;
    end
    @(negedge clk);
    in_if.valid <= 1'b1;
    in_if.start_x <= sx;
    in_if.start_y <= sy;
    in_if.control_x <= cx;
    in_if.control_y <= cy;
    in_if.end_x <= ex;
    in_if.end_y <= ey;
    do @(posedge clk); while (!(in_if.valid && in_if.ready));
  endtask

  function automatic logic signed [23:0] rand_coord(input int spread);
    case (spread)
      0: return 24'($urandom);
      1: return $signed(24'($urandom_range(0, 4095))) - 24'sd2048;
      default: return ($urandom_range(0, 1) == 0) ? CMAX - 24'($urandom_range(0, 255))
                                                  : CMIN + 24'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_random(input bit bunched);
    int s;
    logic signed [23:0] c[6];
    s = $urandom_range(0, 9) < 6 ? 0 : ($urandom_range(0, 2) == 0 ? 2 : 1);
    foreach (c[i]) c[i] = rand_coord(s);
    // Control point near the midpoint of the ends, offset at random, so extrema appear often.
    if ($urandom_range(0, 1) == 0) begin
      c[2] = 24'((longint'(c[0]) + c[4]) / 2 + $signed(24'($urandom_range(0, 65535))) - 32768);
      c[3] = 24'((longint'(c[1]) + c[5]) / 2 - $signed(24'($urandom_range(0, 65535))) + 32768);
    end
    send_curve(c[0], c[1], c[2], c[3], c[4], c[5], bunched ? 0 : $urandom_range(0, 7));
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_curve(0, 0, 0, 0, 0, 0, 0);
    send_curve(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, 0);
    send_curve(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, 1);
    send_curve(CMIN, CMAX, CMAX, CMIN, CMIN, CMAX, 0);
    send_curve(CMAX, CMIN, CMIN, CMAX, CMAX, CMIN, 2);
    send_curve(CMIN, CMIN, 0, 0, CMAX, CMAX, 0);
    send_curve(-24'sd256, 24'sd256, 24'sd512, -24'sd512, 24'sd256, -24'sd256, 0);
    send_curve(0, 0, 24'sd100, 24'sd100, 24'sd200, 24'sd200, 3);
    send_curve(0, 0, 24'sd300, -24'sd300, 0, 0, 0);
    send_curve(24'sd5, 24'sd5, 24'sd5, 24'sd5, 24'sd9, 24'sd9, 0);
    send_curve(0, 0, 24'sd1, 24'sd1, 24'sd2000000, 24'sd2000000, 0);
    send_curve(0, 0, 24'sd1, -24'sd1, 24'sd3, -24'sd3, 0);
    send_curve(24'sd1000, 0, 24'sd3000, 24'sd1, 24'sd1001, 24'sd3, 0);
    send_curve(CMAX, CMAX, CMIN, CMIN, CMAX, CMAX, 0);
    send_curve(24'sh555555, -24'sh2AAAAB, 24'sh2AAAAA, 24'sh555555, -24'sd1, 24'sd1, 0);

    for (int i = 0; i < 500; i++) send_random(i % 100 > 70);

    // Let everything drain before the second half.
    @(negedge clk);
    in_if.valid <= 1'b0;
    wait (scoreboard.pending_boxes.size() == 0);

    for (int i = 0; i < 640; i++) send_random(i % 90 < 30);
    @(negedge clk);
    in_if.valid <= 1'b0;
    sending_done = 1'b1;
  end

  initial begin
    @(posedge rst_n);
    wait ((sending_done && scoreboard.pending_boxes.size() == 0) || timed_out);
    if (!timed_out) begin
      repeat (LATENCY + 10) @(posedge clk);
    end
    if (timed_out || scoreboard.mismatches != 0 || scoreboard.pending_boxes.size() != 0) begin
      $display("[FAIL] regression broken");
    end else begin
      $display("[ OK ] regression clean");
    end
    $finish;
  end
endmodule
